>>> src/ksm_pkg.sv
// Shared constants, codes and types of the KMP stream matcher.
`timescale 1ns / 1ps
`default_nettype none
package ksm_pkg;

	localparam int MAX_PATTERN_DEF   = 32;
	localparam int POSITION_BITS_DEF = 32;

	localparam int PIDX_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 6;
	localparam int START_W = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	typedef struct packed {
		logic idle;
		logic done;
		logic found;
		logic text;
		logic pos_clr;
	} ksm_walk_rsp_t;

endpackage
`default_nettype wire

>>> src/ksm_if.sv
// Channel interfaces of the KMP stream matcher: item, result and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface ksm_item_if;
	import ksm_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [PIDX_W-1:0] pattern_index;
	logic [BYTE_W-1:0] data_byte;
	modport source (output valid, op, pattern_index, data_byte, input ready);
	modport sink (input valid, op, pattern_index, data_byte, output ready);
endinterface

interface ksm_result_if;
	import ksm_pkg::*;
	logic               valid;
	logic               ready;
	logic               matched;
	logic [START_W-1:0] match_start;
	modport source (output valid, matched, match_start, input ready);
	modport sink (input valid, matched, match_start, output ready);
endinterface

interface ksm_cfg_if;
	import ksm_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> src/ksm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ksm_ram #(
	parameter int WIDTH = ksm_pkg::BYTE_W,
	parameter int DEPTH = ksm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> src/ksm_walk.sv
// Failure-link walk sequencer with pattern and failure stores and one shared compare unit.
`timescale 1ns / 1ps
`default_nettype none
module ksm_walk #(
	parameter int MAX_PATTERN = ksm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                op,
	input  wire logic [ksm_pkg::PIDX_W-1:0]          pattern_index,
	input  wire logic [ksm_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic [$clog2(MAX_PATTERN+1)-1:0]    m,
	input  wire logic                                ack,
	output ksm_pkg::ksm_walk_rsp_t                   rsp
);
	import ksm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_PATTERN);
	localparam int JW     = $clog2(MAX_PATTERN + 1);
	localparam int IW     = (JW > PIDX_W) ? JW : PIDX_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_LRD  = 3'd3;
	localparam logic [2:0] S_LNK  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [JW-1:0]     j_q;
	logic [JW-1:0]     bpl_q;
	logic [JW-1:0]     mlen_q;
	logic [ADDR_W-1:0] idx_q;
	logic [BYTE_W-1:0] byte_q;
	logic              op_q;
	logic              found_q;
	logic              pos_clr_q;

	logic              idx_ok;
	logic [ADDR_W-1:0] idx_a;
	logic [JW-1:0]     k_init;
	logic [JW-1:0]     j_init;
	logic [JW-1:0]     jm1;
	logic [JW-1:0]     jn;
	logic [JW-1:0]     lnk;
	logic              eq;
	logic              follow;

	logic              p_we;
	logic [BYTE_W-1:0] p_rdata;
	logic              f_we;
	logic [ADDR_W-1:0] f_waddr;
	logic [JW-1:0]     f_wdata;
	logic [JW-1:0]     f_rdata;

	assign idx_ok = IW'(pattern_index) < IW'(MAX_PATTERN);
	assign idx_a  = ADDR_W'(pattern_index);
	assign k_init = (bpl_q >= JW'(idx_a)) ? '0 : bpl_q;
	assign j_init = (mlen_q >= m) ? '0 : mlen_q;
	assign jm1    = j_q - JW'(1);

	// shared compare and link unit
	assign eq     = (p_rdata == byte_q);
	assign follow = (j_q != '0) && !eq;
	assign jn     = j_q + JW'(eq);
	assign lnk    = (f_rdata < j_q) ? f_rdata : '0;

	assign p_we = start && (state_q == S_IDLE) && (op == OP_LOAD) && idx_ok;

	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q;
		f_wdata = jn;
		if (state_q == S_IDLE) begin
			f_we    = p_we && (idx_a == '0);
			f_waddr = '0;
			f_wdata = '0;
		end else if (state_q == S_CMP) begin
			f_we = (op_q == OP_LOAD) && !follow;
		end
	end

	ksm_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (idx_a),
		.wdata (data_byte),
		.raddr (j_q[ADDR_W-1:0]),
		.rdata (p_rdata)
	);

	ksm_ram #(.WIDTH(JW), .DEPTH(MAX_PATTERN)) u_failure_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (jm1[ADDR_W-1:0]),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			j_q       <= '0;
			bpl_q     <= '0;
			mlen_q    <= '0;
			idx_q     <= '0;
			byte_q    <= '0;
			op_q      <= OP_LOAD;
			found_q   <= 1'b0;
			pos_clr_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op;
						byte_q    <= data_byte;
						idx_q     <= idx_a;
						found_q   <= 1'b0;
						pos_clr_q <= (op == OP_LOAD) && idx_ok;
						if (op == OP_TEXT) begin
							j_q     <= j_init;
							state_q <= S_RD;
						end else if (!idx_ok) begin
							state_q <= S_DONE;
						end else begin
							mlen_q <= '0;
							if (idx_a == '0) begin
								bpl_q   <= '0;
								state_q <= S_DONE;
							end else begin
								j_q     <= k_init;
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (follow) begin
						j_q     <= lnk;
						state_q <= S_RD;
					end else begin
						j_q <= jn;
						if (op_q == OP_LOAD) begin
							bpl_q   <= jn;
							state_q <= S_DONE;
						end else if (jn == m) begin
							found_q <= 1'b1;
							state_q <= S_LRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LRD: begin
					state_q <= S_LNK;
				end
				S_LNK: begin
					j_q     <= lnk;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack) begin
						if (op_q == OP_TEXT) begin
							mlen_q <= j_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp.idle    = (state_q == S_IDLE);
		rsp.done    = (state_q == S_DONE);
		rsp.found   = found_q;
		rsp.text    = (op_q == OP_TEXT);
		rsp.pos_clr = pos_clr_q;
	end
endmodule
`default_nettype wire

>>> src/kmp_stream_matcher.sv
// KMP stream matcher top level: channels, length register, text position and result register.
//
// Usage: items arrive on the item channel. An item with op = 0 loads one pattern
// byte at pattern_index (load indexes 0, 1, 2, ... in order); it rebuilds that
// entry's failure value, and clears the match length and the text position.
// An item with op = 1 is a text byte. When a text byte completes a pattern
// occurrence, one transfer leaves on the result channel with the text position
// of the first matched byte; overlapping occurrences are all reported.
// The cfg channel writes pattern_length (0 counts as 1, values above
// MAX_PATTERN count as MAX_PATTERN); write it only while the block is idle.
// Timing: one item is processed at a time; item ready is low while busy.
// An item steps through a read and a compare state (a load at index zero
// skips both), repeats them for each failure link followed, and adds a link
// read and a link state when a match completes. The walk reads the pattern
// and failure stores via the shared compare unit; a match result is registered.
// Reset clears the length register to 1, the match state and the position;
// pattern contents are undefined until loaded. A stalled result channel holds
// its transfer; the next item is still taken, and only a second match waits.
`timescale 1ns / 1ps
`default_nettype none
module kmp_stream_matcher #(
	parameter int MAX_PATTERN   = ksm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = ksm_pkg::POSITION_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	ksm_item_if.sink      item,
	ksm_result_if.source  result,
	ksm_cfg_if.sink       cfg
);
	import ksm_pkg::*;

	localparam int JW    = $clog2(MAX_PATTERN + 1);
	localparam int CW    = (JW > LEN_W) ? JW : LEN_W;
	localparam int EXT_W = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;

	logic [LEN_W-1:0]         len_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     out_valid_q;
	logic [START_W-1:0]       start_q;

	logic [CW-1:0]            len_c;
	logic [JW-1:0]            m;
	logic                     start;
	logic                     ack;
	logic                     slot_free;
	logic [POSITION_BITS-1:0] start_pos;
	logic [EXT_W-1:0]         start_ext;
	ksm_walk_rsp_t            rsp;

	assign len_c = CW'(len_q);

	always_comb begin
		if (len_c == '0) begin
			m = JW'(1);
		end else if (len_c > CW'(MAX_PATTERN)) begin
			m = JW'(MAX_PATTERN);
		end else begin
			m = JW'(len_c);
		end
	end

	assign item.ready = rsp.idle;
	assign start      = item.valid && rsp.idle;
	assign slot_free  = !out_valid_q || result.ready;
	assign ack        = rsp.done && (!rsp.found || slot_free);
	assign start_pos  = pos_q - POSITION_BITS'(m) + POSITION_BITS'(1);
	assign start_ext  = EXT_W'(start_pos);

	ksm_walk #(.MAX_PATTERN(MAX_PATTERN)) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (item.op),
		.pattern_index (item.pattern_index),
		.data_byte     (item.data_byte),
		.m             (m),
		.ack           (ack),
		.rsp           (rsp)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(1);
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				len_q <= cfg.data;
			end
			if (ack) begin
				if (rsp.text) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end else if (rsp.pos_clr) begin
					pos_q <= '0;
				end
			end
			if (ack && rsp.found) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ack && rsp.found) begin
			start_q <= start_ext[START_W-1:0];
		end
	end

	assign result.valid       = out_valid_q;
	assign result.matched     = 1'b1;
	assign result.match_start = start_q;
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for kmp_stream_matcher: directed and random streams checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import ksm_pkg::*;

	localparam int PAT_DEPTH    = MAX_PATTERN_DEF;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 800000;

	logic clk;
	logic arst_n;

	ksm_item_if   item_ch ();
	ksm_result_if res_ch ();
	ksm_cfg_if    cfg_ch ();

	kmp_stream_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	bit [BYTE_W-1:0]   pat_mem [PAT_DEPTH];
	bit [LEN_W-1:0]    fail_mem [PAT_DEPTH];
	bit                pat_ok [PAT_DEPTH];
	bit                fail_ok [PAT_DEPTH];
	bit [LEN_W-1:0]    build_len;
	bit [LEN_W-1:0]    match_len;
	bit [START_W-1:0]  text_pos;
	bit [LEN_W-1:0]    length_reg;
	logic [START_W-1:0] match_start_q [$];

	int err_count;
	int cycle_count;
	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit [BYTE_W-1:0] pat_byte(input int i, inout bit bad);
		if (!pat_ok[i]) bad = 1'b1;
		return pat_mem[i];
	endfunction

	function automatic int fail_link(input int len, inout bit bad);
		int nxt;
		if (!fail_ok[len-1]) bad = 1'b1;
		nxt = int'(fail_mem[len-1]);
		return (nxt < len) ? nxt : 0;
	endfunction

	function automatic int effective_len(input bit [LEN_W-1:0] v);
		if (v == 0) return 1;
		if (v > PAT_DEPTH) return PAT_DEPTH;
		return int'(v);
	endfunction

	// Returns 1 if the item would read a never-loaded entry; state changes only on commit.
	function automatic bit kmp_predict(input bit commit, input logic op,
			input logic [PIDX_W-1:0] idx, input logic [BYTE_W-1:0] b,
			output bit hit, output logic [START_W-1:0] start);
		int k;
		int j;
		int m;
		bit bad;
		bad = 1'b0;
		hit = 1'b0;
		start = '0;
		if (op == OP_LOAD) begin
			k = 0;
			if (idx != 0) begin
				k = int'(build_len);
				if (k >= idx) k = 0;
				while (k > 0 && pat_byte(k, bad) != b) k = fail_link(k, bad);
				if (pat_byte(k, bad) == b) k++;
			end
			if (commit) begin
				pat_mem[idx] = b;
				pat_ok[idx] = 1'b1;
				fail_mem[idx] = LEN_W'(k);
				fail_ok[idx] = 1'b1;
				build_len = LEN_W'(k);
				match_len = '0;
				text_pos = '0;
			end
			return bad;
		end
		m = effective_len(length_reg);
		j = int'(match_len);
		if (j >= m) j = 0;
		while (j > 0 && pat_byte(j, bad) != b) j = fail_link(j, bad);
		if (pat_byte(j, bad) == b) j++;
		if (j == m) begin
			hit = 1'b1;
			start = text_pos - START_W'(m - 1);
			j = fail_link(m, bad);
		end
		if (commit) begin
			match_len = LEN_W'(j);
			text_pos = text_pos + START_W'(1);
		end
		return bad;
	endfunction

	task automatic report_mismatch(input string field, input logic [START_W-1:0] got,
			input logic [START_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	task automatic send_item(input logic op, input logic [PIDX_W-1:0] idx,
			input logic [BYTE_W-1:0] b);
		bit hit;
		logic [START_W-1:0] start;
		if (kmp_predict(1'b0, op, idx, b, hit, start)) return;
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid         <= 1'b1;
		item_ch.op            <= op;
		item_ch.pattern_index <= idx;
		item_ch.data_byte     <= b;
		do @(posedge clk); while (!item_ch.ready);
		void'(kmp_predict(1'b1, op, idx, b, hit, start));
		if (hit) match_start_q.push_back(start);
		items_sent++;
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (match_start_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input bit [LEN_W-1:0] v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		length_reg = v;
	endtask

	task automatic test_single_byte_pattern();
		send_item(OP_LOAD, 0, 8'hFF);
		send_item(OP_TEXT, 0, 8'hFF);
		send_item(OP_TEXT, 0, 8'h00);
		send_item(OP_TEXT, 0, 8'hFF);
	endtask

	task automatic test_zero_length();
		write_length(0);
		send_item(OP_TEXT, 0, 8'hFF);
		send_item(OP_TEXT, 0, 8'h7F);
	endtask

	task automatic test_overlapping_matches();
		write_length(3);
		send_item(OP_LOAD, 0, "a");
		send_item(OP_LOAD, 1, "b");
		send_item(OP_LOAD, 2, "a");
		send_item(OP_TEXT, 0, "a");
		send_item(OP_TEXT, 0, "b");
		send_item(OP_TEXT, 0, "a");
		send_item(OP_TEXT, 0, "b");
		send_item(OP_TEXT, 0, "a");
	endtask

	task automatic test_out_of_order_load();
		send_item(OP_LOAD, 1, "a");
		send_item(OP_LOAD, 31, 8'h00);
		repeat (4) send_item(OP_TEXT, 31, "a");
	endtask

	task automatic test_stale_match_length();
		send_item(OP_TEXT, 0, "b");
		send_item(OP_TEXT, 0, "a");
		send_item(OP_TEXT, 0, "a");
		write_length(2);
		send_item(OP_TEXT, 0, "a");
		send_item(OP_TEXT, 0, "a");
	endtask

	task automatic test_random_streams();
		int base;
		int m;
		int r;
		int pl;
		int n_text;
		int alpha_n;
		bit [LEN_W-1:0] v;
		bit [BYTE_W-1:0] alpha [3];
		logic [BYTE_W-1:0] text_q [$];
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			case ((items_sent - base) * 3 / RANDOM_ITEMS)
				0: begin
					send_idle_pct = 36;
					recv_stall_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_stall_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			r = $urandom_range(99);
			if (r < 8) v = '0;
			else if (r < 16) v = LEN_W'($urandom_range(63, 33));
			else if (r < 22) v = LEN_W'(PAT_DEPTH);
			else if (r < 32) v = LEN_W'($urandom_range(31, 9));
			else v = LEN_W'($urandom_range(8, 1));
			write_length(v);
			m = effective_len(v);
			alpha_n = $urandom_range(3, 1);
			foreach (alpha[i]) alpha[i] = BYTE_W'($urandom_range(255));
			for (int i = 0; i < m; i++) begin
				if ($urandom_range(9) == 0)
					send_item(OP_LOAD, PIDX_W'(i), BYTE_W'($urandom_range(255)));
				else
					send_item(OP_LOAD, PIDX_W'(i), alpha[$urandom_range(alpha_n - 1)]);
			end
			text_q.delete();
			n_text = $urandom_range(60, 20);
			for (int t = 0; t < n_text; t++) begin
				if (t == n_text / 2 && $urandom_range(4) == 0) begin
					v = LEN_W'($urandom_range(m, 1));
					write_length(v);
					m = effective_len(v);
				end
				if ($urandom_range(99) < 3)
					send_item(OP_LOAD, PIDX_W'($urandom_range(31)),
						BYTE_W'($urandom_range(255)));
				if (text_q.size() == 0) begin
					r = $urandom_range(99);
					pl = (r < 35) ? m : $urandom_range(m, 1);
					if (r < 45) begin
						for (int i = 0; i < pl; i++) text_q.push_back(pat_mem[i]);
					end else if (r < 50) begin
						text_q.push_back(BYTE_W'($urandom_range(255)));
					end else begin
						text_q.push_back(alpha[$urandom_range(alpha_n - 1)]);
					end
				end
				send_item(OP_TEXT, PIDX_W'($urandom_range(31)), text_q.pop_front());
			end
		end
	endtask

	always @(posedge clk) begin
		logic [START_W-1:0] want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (match_start_q.size() == 0) begin
					report_mismatch("unexpected match_start", res_ch.match_start, '0);
				end else begin
					want = match_start_q.pop_front();
					if (res_ch.matched !== 1'b1)
						report_mismatch("matched", START_W'(res_ch.matched), 1);
					if (res_ch.match_start !== want)
						report_mismatch("match_start", res_ch.match_start, want);
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.op            = OP_LOAD;
		item_ch.pattern_index = '0;
		item_ch.data_byte     = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.data           = '0;
		length_reg            = 1;
		send_idle_pct         = 36;
		recv_stall_pct        = 60;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_byte_pattern();
		test_zero_length();
		test_overlapping_matches();
		test_out_of_order_load();
		test_stale_match_length();
		test_random_streams();
		wait_idle();
		if (err_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
